// ----- hw/rtl/bse_pkg.sv -----
// Shared types, constants and helpers of the bitmap store engine.
package bse_pkg;

	localparam int BITS_DEFAULT = 1024;
	localparam int WORD_BITS    = 32;
	localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;

	localparam int CFG_W  = 11;
	localparam int CMD_W  = 3;
	localparam int POS_W  = 10;
	localparam int WIDX_W = 5;
	localparam int IN_W   = 64;
	localparam int OUT_W  = 16;

	localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [3:0] {
		OP_WRITE_BIT   = 4'd0,
		OP_WRITE_RANGE = 4'd1,
		OP_WRITE_ALL   = 4'd2,
		OP_FLIP_BIT    = 4'd3,
		OP_FLIP_ALL    = 4'd4,
		OP_TEST        = 4'd5,
		OP_FIND_NEXT   = 4'd6,
		OP_WRITE_WORD  = 4'd7,
		OP_REFRESH     = 4'd8,
		OP_CLEAR       = 4'd9
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_MODIFY,
		ST_RESULT
	} state_t;

	// Index of the lowest set bit; zero when none is set.
	function automatic logic [4:0] lowest_set(input logic [WORD_BITS-1:0] w);
		logic [4:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (w[i]) begin
				idx = 5'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ----- hw/rtl/bitmap_store_engine.sv -----
// Bitmap store engine: word memory with read-modify-write walker and find-next search.
//
// Commands enter on the s_axis channel (command in tuser, arguments in tdata) and one
// result transaction per command leaves on the m_axis channel. The bits in use are set
// through cfg_we/cfg_wdata; a value of zero counts as one, a value above BITS as BITS.
// The bitmap lives in a single-port-write, one-read memory of BITS/32 words with a
// registered read port. A command reads its first word in the cycle it is
// accepted, then modifies and writes back one word per cycle, reading the next word
// at the same time.
// Single-word commands (write bit, flip bit, test, write word) pass through the modify
// and result states; the engine takes the next command only once it is idle again.
// Range writes walk the words the range covers, write all and flip all every word,
// and find next the words up to the first match or the last word in use.
// Reset starts a clearing pass over every word with s_axis_tready low. A config
// write starts a refresh pass over every word that masks off bits beyond the new count.
// A waiting result is held in the output register while m_axis_tready is low; the
// next command is still accepted and runs until its own result is ready.
module bitmap_store_engine
	import bse_pkg::*;
#(
	parameter int BITS = BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	// position[9:0], end_position[19:10], value[20], word_index[25:21],
	// word_data[57:26], zero fill [63:58]
	input  logic [IN_W-1:0]  s_axis_tdata,
	// command[2:0]
	input  logic [CMD_W-1:0] s_axis_tuser,
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// bit_value[0], found[1], found_position[11:2], any_set[12], all_set[13],
	// out_of_range[14], zero fill [15]
	output logic [OUT_W-1:0] m_axis_tdata
);

	localparam int NWORDS = (BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
	localparam int SW     = $clog2(BITS + 1);
	localparam int CW0    = (SW > CFG_W) ? SW : CFG_W;
	localparam int CW     = (CW0 > AW + 5) ? CW0 : AW + 5;
	localparam logic [CW-1:0] BITS_C   = CW'(BITS);
	localparam logic [CW-1:0] SIZE_RST = (CW'(SIZE_RESET) > BITS_C) ? BITS_C : CW'(SIZE_RESET);
	localparam logic [AW-1:0] LAST_WORD = AW'(NWORDS - 1);

	// control
	state_t state_q, state_d;
	op_t op_q;
	logic [AW-1:0] addr_q, first_q, last_q;
	logic [CW-1:0] size_q;
	logic [NWORDS-1:0] nonzero_q, full_q;
	logic m_axis_tvalid_q;

	// command payload
	logic [POS_W-1:0] pos_q, endc_q;
	logic empty_q, val_q;
	logic [WIDX_W-1:0] widx_q;
	logic [WORD_BITS-1:0] wdata_q;

	// result payload
	logic res_bitv_q, res_found_q, res_oor_q;
	logic [POS_W-1:0] res_fpos_q;
	logic [OUT_W-1:0] m_axis_tdata_q;

	// memory
	logic [WORD_BITS-1:0] bit_words_q [NWORDS];
	logic [WORD_BITS-1:0] rd_word_s1;
	logic [AW-1:0] raddr;
	logic mem_we;

	// input decode
	logic [CMD_W-1:0] in_cmd;
	op_t in_op;
	logic [POS_W-1:0] in_pos, in_end, endc_in;
	logic in_val, empty_in;
	logic [WIDX_W-1:0] in_widx;
	logic [WORD_BITS-1:0] in_wdata;
	logic [CW-1:0] size_m1, cfg_size;
	logic [AW-1:0] start_in, last_in;
	logic accept, out_free, out_load;

	// modify datapath
	logic [CW-1:0] base, rem;
	logic [WORD_BITS-1:0] umask, bmask, rmask, lomask, cand, new_word;
	logic [4:0] lo, hi, hit_idx;
	logic pos_in, widx_ok, do_write, hit, walk_done, sweep_op;
	logic [POS_W-1:0] fpos;

	assign in_cmd   = s_axis_tuser;
	assign in_op    = op_t'({1'b0, in_cmd});
	assign in_pos   = s_axis_tdata[9:0];
	assign in_end   = s_axis_tdata[19:10];
	assign in_val   = s_axis_tdata[20];
	assign in_widx  = s_axis_tdata[25:21];
	assign in_wdata = s_axis_tdata[57:26];

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid_q || m_axis_tready;
	assign size_m1  = size_q - CW'(1);

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_size = CW'(1);
		end else if (CW'(cfg_wdata) > BITS_C) begin
			cfg_size = BITS_C;
		end else begin
			cfg_size = CW'(cfg_wdata);
		end
	end

	// clip the range end to the last bit in use
	always_comb begin
		if (CW'(in_end) > size_m1) begin
			endc_in = size_m1[POS_W-1:0];
		end else begin
			endc_in = in_end;
		end
		empty_in = in_pos > endc_in;
	end

	always_comb begin
		case (in_op)
			OP_WRITE_WORD: start_in = AW'(in_widx);
			OP_WRITE_ALL, OP_FLIP_ALL: start_in = '0;
			default: start_in = AW'(in_pos[9:5]);
		endcase
		// an empty range stays on its first word
		case (in_op)
			OP_WRITE_RANGE: last_in = empty_in ? start_in : AW'(endc_in[9:5]);
			OP_WRITE_ALL, OP_FLIP_ALL, OP_FIND_NEXT: last_in = LAST_WORD;
			default: last_in = start_in;
		endcase
	end

	// bits of the current word that are in use
	always_comb begin
		base = CW'({addr_q, 5'b00000});
		rem  = size_q - base;
		if (base >= size_q) begin
			umask = '0;
		end else if (rem >= CW'(WORD_BITS)) begin
			umask = FULL_WORD;
		end else begin
			umask = (32'h1 << rem[4:0]) - 32'h1;
		end
	end

	always_comb begin
		pos_in  = CW'(pos_q) < size_q;
		widx_ok = CW'(widx_q) < CW'(NWORDS);
		bmask   = 32'h1 << pos_q[4:0];
		lo      = (addr_q == first_q) ? pos_q[4:0] : 5'd0;
		hi      = (addr_q == last_q) ? endc_q[4:0] : 5'd31;
		rmask   = (FULL_WORD << lo) & (FULL_WORD >> (5'd31 - hi));
		lomask  = (addr_q == first_q) ? (FULL_WORD << pos_q[4:0]) : FULL_WORD;
		cand    = (val_q ? rd_word_s1 : ~rd_word_s1) & umask & lomask;
		hit     = |cand;
		hit_idx = lowest_set(cand);
		fpos    = POS_W'({addr_q, hit_idx});
	end

	always_comb begin
		do_write = 1'b0;
		new_word = rd_word_s1;
		case (op_q)
			OP_WRITE_BIT: begin
				do_write = pos_in;
				new_word = val_q ? (rd_word_s1 | bmask) : (rd_word_s1 & ~bmask);
			end
			OP_WRITE_RANGE: begin
				do_write = !empty_q;
				new_word = val_q ? (rd_word_s1 | rmask) : (rd_word_s1 & ~rmask);
			end
			OP_WRITE_ALL: begin
				do_write = 1'b1;
				new_word = val_q ? umask : '0;
			end
			OP_FLIP_BIT: begin
				do_write = pos_in;
				new_word = rd_word_s1 ^ bmask;
			end
			OP_FLIP_ALL: begin
				do_write = 1'b1;
				new_word = ~rd_word_s1 & umask;
			end
			OP_WRITE_WORD: begin
				do_write = widx_ok && (umask != '0);
				new_word = wdata_q & umask;
			end
			OP_REFRESH: begin
				do_write = 1'b1;
				new_word = rd_word_s1 & umask;
			end
			OP_CLEAR: begin
				do_write = 1'b1;
				new_word = '0;
			end
			default: begin
				do_write = 1'b0;
				new_word = rd_word_s1;
			end
		endcase
	end

	always_comb begin
		sweep_op = (op_q == OP_REFRESH) || (op_q == OP_CLEAR);
		case (op_q)
			OP_WRITE_RANGE: walk_done = empty_q || (addr_q == last_q);
			OP_WRITE_ALL, OP_FLIP_ALL, OP_REFRESH, OP_CLEAR: walk_done = addr_q == last_q;
			OP_FIND_NEXT: walk_done = hit || (umask != FULL_WORD) || (addr_q == last_q);
			default: walk_done = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_MODIFY;
				end
			end
			ST_PREP: state_d = ST_MODIFY;
			ST_MODIFY: begin
				if (walk_done) begin
					state_d = sweep_op ? ST_IDLE : ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
		if (cfg_we) begin
			state_d = ST_PREP;
		end
	end

	// state outputs
	always_comb begin
		s_axis_tready = 1'b0;
		mem_we        = 1'b0;
		out_load      = 1'b0;
		raddr         = addr_q;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = !cfg_we;
				raddr         = start_in;
			end
			ST_PREP: raddr = addr_q;
			ST_MODIFY: begin
				mem_we = do_write;
				raddr  = addr_q + AW'(1);
			end
			ST_RESULT: out_load = out_free;
			default: raddr = addr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bit_words_q[addr_q] <= new_word;
		end
		rd_word_s1 <= bit_words_q[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_PREP;
			op_q            <= OP_CLEAR;
			addr_q          <= '0;
			first_q         <= '0;
			last_q          <= LAST_WORD;
			size_q          <= SIZE_RST;
			nonzero_q       <= '0;
			full_q          <= '0;
			m_axis_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				size_q  <= cfg_size;
				op_q    <= OP_REFRESH;
				addr_q  <= '0;
				first_q <= '0;
				last_q  <= LAST_WORD;
			end else if (accept) begin
				op_q    <= in_op;
				addr_q  <= start_in;
				first_q <= start_in;
				last_q  <= last_in;
			end else if (state_q == ST_MODIFY && !walk_done) begin
				addr_q <= addr_q + AW'(1);
			end
			if (mem_we) begin
				nonzero_q[addr_q] <= new_word != '0;
				full_q[addr_q]    <= new_word == umask;
			end
			if (out_load) begin
				m_axis_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q   <= in_pos;
			endc_q  <= endc_in;
			empty_q <= empty_in;
			val_q   <= in_val;
			widx_q  <= in_widx;
			wdata_q <= in_wdata;
		end
		// hold the last word's outcome; only the finishing cycle matters
		if (state_q == ST_MODIFY) begin
			res_bitv_q  <= (op_q == OP_TEST) && pos_in && rd_word_s1[pos_q[4:0]];
			res_found_q <= (op_q == OP_FIND_NEXT) && hit;
			res_fpos_q  <= ((op_q == OP_FIND_NEXT) && hit) ? fpos : '0;
			res_oor_q   <= (op_q == OP_FLIP_BIT) && !pos_in;
		end
		if (out_load) begin
			m_axis_tdata_q <= {1'b0, res_oor_q, &full_q, |nonzero_q,
				res_fpos_q, res_found_q, res_bitv_q};
		end
	end

	assign m_axis_tvalid = m_axis_tvalid_q;
	assign m_axis_tdata  = m_axis_tdata_q;

	a_accept_starts_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !cfg_we) |=> (state_q == ST_MODIFY))
		else $error("accepted transaction did not start a word walk");

	a_result_from_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_RESULT))
		else $error("result presented outside the result state");

	a_walk_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODIFY) |-> (addr_q <= last_q))
		else $error("word walk ran past its last word");

	a_cfg_restarts_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == ST_PREP) && (addr_q == '0) && (op_q == OP_REFRESH))
		else $error("config write did not start a refresh pass");

	a_no_accept_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MODIFY && sweep_op) |-> !s_axis_tready)
		else $error("input taken during a clearing or refresh pass");

endmodule

// ----- bench/bitmap_store_engine_test.sv -----
// Self-checking testbench of the bitmap store engine: directed and random commands, scoreboard.
import bse_pkg::*;

typedef struct packed {
	logic [WORD_BITS-1:0] word_data;
	logic [WIDX_W-1:0]    word_index;
	logic                 value;
	logic [POS_W-1:0]     end_position;
	logic [POS_W-1:0]     position;
} bitmap_cmd_t;

typedef struct packed {
	logic             out_of_range;
	logic             all_set;
	logic             any_set;
	logic [POS_W-1:0] found_position;
	logic             found;
	logic             bit_value;
} bitmap_result_t;

class bitmap_mirror;
	localparam int NWORDS = BITS_DEFAULT / WORD_BITS;

	logic [WORD_BITS-1:0] words [NWORDS];
	int size;
	bitmap_result_t awaited [$];
	int errors;

	function new();
		foreach (words[w]) words[w] = '0;
		size = BITS_DEFAULT;
		errors = 0;
	endfunction

	function logic [WORD_BITS-1:0] used_mask(int w);
		int base;
		base = w * WORD_BITS;
		if (base >= size) return '0;
		if (size - base >= WORD_BITS) return FULL_WORD;
		return (32'd1 << (size - base)) - 32'd1;
	endfunction

	function void mask_words();
		foreach (words[w]) words[w] &= used_mask(w);
	endfunction

	function void set_size(logic [CFG_W-1:0] v);
		if (v == '0) size = 1;
		else if (v > 11'd1024) size = BITS_DEFAULT;
		else size = int'(v);
		mask_words();
	endfunction

	function logic get_bit(int p);
		if (p >= size) return 1'b0;
		return words[p / WORD_BITS][p % WORD_BITS];
	endfunction

	function void put_bit(int p, logic v);
		if (p >= size) return;
		words[p / WORD_BITS][p % WORD_BITS] = v;
	endfunction

	// Apply one accepted command and queue the result it must produce.
	function void note_command(op_t op, bitmap_cmd_t c);
		bitmap_result_t r;
		int last;
		r = '0;
		case (op)
			OP_WRITE_BIT: put_bit(c.position, c.value);
			OP_WRITE_RANGE: begin
				last = c.end_position;
				if (last > size - 1) last = size - 1;
				for (int p = c.position; p <= last; p++) put_bit(p, c.value);
			end
			OP_WRITE_ALL: foreach (words[w]) words[w] = c.value ? used_mask(w) : '0;
			OP_FLIP_BIT: begin
				if (c.position >= size) r.out_of_range = 1'b1;
				else put_bit(c.position, !get_bit(c.position));
			end
			OP_FLIP_ALL: foreach (words[w]) words[w] = ~words[w] & used_mask(w);
			OP_TEST: r.bit_value = get_bit(c.position);
			OP_FIND_NEXT: begin
				for (int p = c.position; p < size; p++) begin
					if (get_bit(p) == c.value) begin
						r.found = 1'b1;
						r.found_position = POS_W'(p);
						break;
					end
				end
			end
			OP_WRITE_WORD: begin
				if (used_mask(c.word_index) != '0)
					words[c.word_index] = c.word_data & used_mask(c.word_index);
			end
			default: ;
		endcase
		mask_words();
		r.all_set = 1'b1;
		foreach (words[w]) begin
			if (words[w] != '0) r.any_set = 1'b1;
			if (words[w] != used_mask(w)) r.all_set = 1'b0;
		end
		awaited.push_back(r);
	endfunction

	function void compare_field(string name, logic [POS_W-1:0] e, logic [POS_W-1:0] a);
		if (a !== e) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			errors++;
		end
	endfunction

	function void check_result(logic [OUT_W-1:0] got);
		bitmap_result_t e, a;
		a = got[14:0];
		if (awaited.size() == 0) begin
			$error("result transaction with no command waiting: tdata %h", got);
			errors++;
			return;
		end
		e = awaited.pop_front();
		compare_field("bit_value", e.bit_value, a.bit_value);
		compare_field("found", e.found, a.found);
		compare_field("found_position", e.found_position, a.found_position);
		compare_field("any_set", e.any_set, a.any_set);
		compare_field("all_set", e.all_set, a.all_set);
		compare_field("out_of_range", e.out_of_range, a.out_of_range);
		compare_field("zero fill", 1'b0, got[15]);
	endfunction
endclass

module bitmap_store_engine_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int PHASE_ITEMS = 150;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [IN_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0] s_axis_tuser = '0;
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;

	bitmap_mirror mirror = new();
	int src_idle_pct = 0;
	int sink_idle_pct = 0;
	int stall_cycles = 0;

	bitmap_store_engine u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Check result transactions, count stalled cycles, throttle the receiver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) mirror.check_result(m_axis_tdata);
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
		end
		m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic bitmap_cmd_t make_cmd(int pos, int endp, logic val, int widx,
			logic [WORD_BITS-1:0] wdata);
		bitmap_cmd_t c;
		c.position = POS_W'(pos);
		c.end_position = POS_W'(endp);
		c.value = val;
		c.word_index = WIDX_W'(widx);
		c.word_data = wdata;
		return c;
	endfunction

	task automatic send_command(op_t op, bitmap_cmd_t c);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= CMD_W'(op);
		s_axis_tdata <= IN_W'(c);
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		mirror.note_command(op, c);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold off the sender until every queued result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (mirror.awaited.size() > 0) @(posedge clk);
	endtask

	task automatic set_size(logic [CFG_W-1:0] v);
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_size(v);
	endtask

	task automatic send_random(int n);
		for (int i = 0; i < n; i++) begin
			op_t op;
			bitmap_cmd_t c;
			int sz, nw, tmp;
			sz = mirror.size;
			nw = (sz + WORD_BITS - 1) / WORD_BITS;
			op = op_t'($urandom_range(7));
			if ($urandom_range(9) < 8) c.position = POS_W'($urandom_range(sz - 1));
			else c.position = POS_W'($urandom());
			case ($urandom_range(9))
				0, 1, 2, 3, 4: begin
					tmp = int'(c.position) + int'($urandom_range(40));
					if (tmp > 1023) tmp = 1023;
					c.end_position = POS_W'(tmp);
				end
				5, 6, 7: c.end_position = POS_W'($urandom_range(sz - 1));
				default: c.end_position = POS_W'($urandom());
			endcase
			c.value = 1'($urandom_range(1));
			if ($urandom_range(9) < 8) c.word_index = WIDX_W'($urandom_range(nw - 1));
			else c.word_index = WIDX_W'($urandom());
			case ($urandom_range(3))
				0: c.word_data = '0;
				1: c.word_data = FULL_WORD;
				default: c.word_data = $urandom();
			endcase
			if (i == n / 2) drain();
			send_command(op, c);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] sizes [10];
		sizes = '{11'd1, 11'd2047, 11'd32, 11'd33, 11'd0, 11'd1023, 11'd31, 11'd64,
			11'd1024, 11'($urandom_range(1024, 1))};
		src_idle_pct = 30;
		sink_idle_pct = 72;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		// Full-size map: empty, full, edges, empty range, whole words.
		send_command(OP_TEST, make_cmd(0, 0, 1'b0, 0, '0));
		send_command(OP_FIND_NEXT, make_cmd(0, 0, 1'b1, 0, '0));
		send_command(OP_FIND_NEXT, make_cmd(1023, 0, 1'b0, 0, '0));
		send_command(OP_WRITE_BIT, make_cmd(1023, 0, 1'b1, 0, '0));
		send_command(OP_WRITE_BIT, make_cmd(0, 0, 1'b1, 0, '0));
		send_command(OP_WRITE_RANGE, make_cmd(0, 1023, 1'b1, 0, '0));
		send_command(OP_FIND_NEXT, make_cmd(0, 0, 1'b0, 0, '0));
		send_command(OP_FLIP_BIT, make_cmd(512, 0, 1'b0, 0, '0));
		send_command(OP_WRITE_RANGE, make_cmd(700, 600, 1'b0, 0, '0));
		send_command(OP_WRITE_ALL, make_cmd(0, 0, 1'b0, 0, '0));
		send_command(OP_WRITE_WORD, make_cmd(0, 0, 1'b0, 31, FULL_WORD));
		send_command(OP_WRITE_WORD, make_cmd(0, 0, 1'b0, 0, 32'hA5A5_5A5A));
		send_command(OP_FLIP_ALL, make_cmd(0, 0, 1'b0, 0, '0));
		send_command(OP_TEST, make_cmd(1023, 0, 1'b0, 0, '0));
		send_command(OP_FIND_NEXT, make_cmd(5, 0, 1'b1, 0, '0));

		// Partial map: everything beyond the bits in use is ignored or flagged.
		set_size(11'd40);
		send_command(OP_FLIP_BIT, make_cmd(40, 0, 1'b0, 0, '0));
		send_command(OP_FLIP_BIT, make_cmd(1023, 0, 1'b0, 0, '0));
		send_command(OP_WRITE_BIT, make_cmd(50, 0, 1'b1, 0, '0));
		send_command(OP_WRITE_RANGE, make_cmd(30, 1023, 1'b1, 0, '0));
		send_command(OP_WRITE_WORD, make_cmd(0, 0, 1'b0, 1, FULL_WORD));
		send_command(OP_WRITE_WORD, make_cmd(0, 0, 1'b0, 2, FULL_WORD));
		send_command(OP_FIND_NEXT, make_cmd(45, 0, 1'b0, 0, '0));
		send_command(OP_TEST, make_cmd(45, 0, 1'b0, 0, '0));
		send_command(OP_WRITE_ALL, make_cmd(0, 0, 1'b1, 0, '0));
		send_command(OP_FIND_NEXT, make_cmd(0, 0, 1'b0, 0, '0));

		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 3) begin
				src_idle_pct = 30;
				sink_idle_pct = 72;
			end else if (ph < 6) begin
				src_idle_pct = 72;
				sink_idle_pct = 30;
			end else begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end
			set_size(sizes[ph]);
			send_random(PHASE_ITEMS);
		end

		drain();
		repeat (SETTLE_CYCLES + 20) @(posedge clk);
		if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
